// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Cursor register widths cover the full range of the geometry parameters
  // (up to 128 columns and 64 rows).
  localparam int COL_W = 7;
  localparam int ROW_W = 6;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  // Result field widths
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_ADDR_W = 11;

  // Operation codes
  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
  localparam logic [CHAR_W-1:0] BS_CHAR     = 8'h08;
  localparam logic [CHAR_W-1:0] TAB_CHAR    = 8'h09;
  localparam logic [CHAR_W-1:0] CR_CHAR     = 8'h0D;
  localparam logic [CHAR_W-1:0] LF_CHAR     = 8'h0A;
  localparam logic [CHAR_W-1:0] PRINT_LIMIT = 8'h80;

  // Configuration register indexes
  localparam logic REG_TEXT_ATTR  = 1'b0;
  localparam logic REG_BLANK_ATTR = 1'b1;

  localparam logic [ATTR_W-1:0] RESET_TEXT_ATTR  = 8'h07;
  localparam logic [ATTR_W-1:0] RESET_BLANK_ATTR = 8'h0F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_FILL
  } tcw_state_t;

  // Outcome of one cursor update
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             written;
    logic             scroll;
  } step_t;

endpackage

// ===== src/tcw_cursor_step.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor_step
// Next cursor position for one command, with wrap and scroll detection.
// ----------------------------------------------------------------------------
module tcw_cursor_step #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       op,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::COL_W-1:0]  col,
  input  logic [tcw_pkg::ROW_W-1:0]  row,
  output tcw_pkg::step_t             step
);
  import tcw_pkg::*;

  localparam logic [COL_W:0] COLS_C = (COL_W+1)'(COLUMNS);
  localparam logic [ROW_W:0] ROWS_C = (ROW_W+1)'(ROWS);

  logic [COL_W:0] col_w;
  logic [ROW_W:0] row_w;
  logic           written;
  logic           scroll;

  always_comb begin
    col_w   = {1'b0, col};
    row_w   = {1'b0, row};
    written = 1'b0;
    scroll  = 1'b0;
    if (op == OP_CLEAR) begin
      col_w = '0;
      row_w = '0;
    end else begin
      case (char_code)
        BS_CHAR: begin
          if (col_w != '0) col_w = col_w - 1'b1;
        end
        TAB_CHAR: begin
          col_w = (col_w + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
        end
        CR_CHAR: begin
          col_w = '0;
        end
        LF_CHAR: begin
          col_w = '0;
          row_w = row_w + 1'b1;
        end
        default: begin
          if (char_code >= SPACE_CHAR && char_code < PRINT_LIMIT) begin
            written = 1'b1;
            col_w   = col_w + 1'b1;
          end
        end
      endcase
      // wrap past the last column
      if (col_w >= COLS_C) begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
      // past the bottom row: clamp and request a scroll
      if (row_w >= ROWS_C) begin
        scroll = 1'b1;
        row_w  = ROWS_C - 1'b1;
      end
    end
    step.col     = col_w[COL_W-1:0];
    step.row     = row_w[ROW_W-1:0];
    step.written = written;
    step.scroll  = scroll;
  end

endmodule

// ===== src/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: cell store, cursor, wrap, scroll and clear.
// ----------------------------------------------------------------------------
// Result: done is registered and rises in the cycle after its command beat.
// Throughput: put of a character or control byte that does not scroll: one
//   beat per cycle, busy stays low. A put that scrolls holds busy for a row
//   copy through the single cell memory, then a bottom row fill; clear holds
//   busy while it writes the whole store, one cell per cycle.
// Reset: synchronous; the store is blanked by a sweep of every cell with
//   busy high. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  // result channel
  output logic                           done,
  output logic [tcw_pkg::OUT_COL_W-1:0]  cursor_column,
  output logic [tcw_pkg::OUT_ROW_W-1:0]  cursor_row,
  output logic [tcw_pkg::OUT_ADDR_W-1:0] cursor_location,
  output logic                           cell_written,
  output logic [tcw_pkg::OUT_ADDR_W-1:0] cell_address,
  output logic [tcw_pkg::CELL_W-1:0]     cell_value,
  // configuration port
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  // cells moved by a scroll: every row but the top one
  localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] FILL_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

  // state and sweep control
  tcw_state_t        state, state_next;
  logic [AW-1:0]     cnt, cnt_next;
  logic              copy_pend;
  logic [AW-1:0]     copy_wa;
  logic [CELL_W-1:0] blank_q;

  // cursor and attributes
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [ATTR_W-1:0] text_attr;
  logic [ATTR_W-1:0] blank_attr;

  // cell memory
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [CELL_W-1:0] mem_wd;

  logic              accept;
  step_t             step;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     loc_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  tcw_cursor_step #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_step (
    .op        (op),
    .char_code (char_code),
    .col       (col_q),
    .row       (row_q),
    .step      (step)
  );

  // cell under the cursor before the beat, and cursor location after it
  assign cur_addr = AW'(int'(row_q) * COLUMNS + int'(col_q));
  assign loc_next = AW'(int'(step.row) * COLUMNS + int'(step.col));

  // ---------------------------------------------------------------------------
  // Configuration: take writes at any time, drop unknown indexes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr  <= RESET_TEXT_ATTR;
      blank_attr <= RESET_BLANK_ATTR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TEXT_ATTR:  text_attr  <= cfg_data;
        REG_BLANK_ATTR: blank_attr <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. IDLE takes beats; COPY walks rows up one cell per cycle (the
  // read runs one row ahead of the write, so no entry is read after it is
  // overwritten); FILL writes blanks from cnt to the last cell.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_CLEAR) begin
            state_next = ST_FILL;
            cnt_next   = '0;
          end else if (step.scroll) begin
            state_next = ST_COPY;
            cnt_next   = '0;
          end
        end
      end
      ST_COPY: begin
        if (cnt == COPY_LAST) begin
          state_next = ST_FILL;
          cnt_next   = FILL_BASE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FILL: begin
        // hold while the last copied cell drains into the memory
        if (!copy_pend) begin
          if (cnt == CELL_LAST) begin
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // copy pipeline: read issued this cycle is written back next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_pend <= 1'b0;
    end else begin
      copy_pend <= (state == ST_COPY);
    end
  end

  always_ff @(posedge clk) begin
    copy_wa <= cnt;
    // latch the blank cell at the start of each sweep
    if (rst) begin
      blank_q <= {RESET_BLANK_ATTR, SPACE_CHAR};
    end else if (accept) begin
      blank_q <= {blank_attr, SPACE_CHAR};
    end
  end

  assign rd_addr = cnt + ROW_STEP;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt;
    mem_wd = blank_q;
    if (copy_pend) begin
      mem_we = 1'b1;
      mem_wa = copy_wa;
      mem_wd = rdata_q;
    end else if (state == ST_FILL) begin
      mem_we = 1'b1;
    end else if (accept && op == OP_PUT && step.written) begin
      mem_we = 1'b1;
      mem_wa = cur_addr;
      mem_wd = {text_attr, char_code};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Cursor and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
      row_q <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        col_q <= step.col;
        row_q <= step.row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cursor_column   <= step.col;
      cursor_row      <= step.row[OUT_ROW_W-1:0];
      cursor_location <= OUT_ADDR_W'(loc_next);
      cell_written    <= step.written;
      cell_address    <= step.written ? OUT_ADDR_W'(cur_addr) : '0;
      cell_value      <= step.written ? {text_attr, char_code} : '0;
    end
  end

endmodule

// ===== src/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           op,
  input logic                           done,
  input logic [tcw_pkg::OUT_COL_W-1:0]  cursor_column,
  input logic [tcw_pkg::OUT_ROW_W-1:0]  cursor_row,
  input logic [tcw_pkg::OUT_ADDR_W-1:0] cursor_location,
  input logic                           cell_written,
  input logic [tcw_pkg::OUT_ADDR_W-1:0] cell_address,
  input logic [tcw_pkg::CELL_W-1:0]     cell_value
);
  import tcw_pkg::*;

  // a result beat follows exactly one command beat
  a_done_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result beat without a command beat");

  // reset starts the blanking sweep
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low after reset");

  // no cell written: address and value read zero
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !cell_written) |-> (cell_address == '0 && cell_value == '0))
    else $error("cell fields set without a write");

  // only printable characters are stored
  a_printable: assert property (@(posedge clk) disable iff (rst)
    (done && cell_written) |->
      (cell_value[7:0] >= SPACE_CHAR && cell_value[7:0] < PRINT_LIMIT))
    else $error("stored character not printable");

  // a clear homes the cursor
  a_clear_home: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_CLEAR) |=>
      (cursor_column == '0 && cursor_row == '0 && cursor_location == '0))
    else $error("clear did not home the cursor");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
